// ===== rtl/mnc_pkg.sv =====
// ----------------------------------------------------------------------------
// mnc_pkg
// Shared types and constants for the masked normalized convolution block.
// ----------------------------------------------------------------------------
package mnc_pkg;

  localparam int MaxCols   = 128;
  localparam int MaxRows   = 128;
  localparam int MaxRadius = 7;
  localparam int KSide     = 2 * MaxRadius + 1;
  localparam int KDepth    = KSide * KSide;
  localparam int GDepth    = MaxCols * MaxRows;
  localparam int ColW      = $clog2(MaxCols);
  localparam int RowW      = $clog2(MaxRows);
  localparam int GAddrW    = $clog2(GDepth);
  localparam int KAddrW    = $clog2(KDepth);
  localparam int DivSteps  = 64;

  typedef enum logic [1:0] {
    CMD_LOAD_GRID   = 2'd0,
    CMD_LOAD_KERNEL = 2'd1,
    CMD_SMOOTH      = 2'd2,
    CMD_NONE        = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_COLS   = 2'd0,
    CFG_ROWS   = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;     // latch target, clear accumulators, reset window position
    logic step;      // issue read of current window position, advance
    logic div_start; // load divider
    logic div_step;  // one quotient bit
    logic finish;    // form result
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic last_pos;  // current position is the last of the window
    logic pipe_busy; // reads still in flight
  } stat_t;

endpackage

// ===== rtl/mnc_datapath.sv =====
// ----------------------------------------------------------------------------
// mnc_datapath
// Grid and kernel stores, window walk, multiply-accumulate and serial divider.
// ----------------------------------------------------------------------------
module mnc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mnc_pkg::ctrl_t       ctrl,
  output mnc_pkg::stat_t       stat,
  input  logic                 grid_we,
  input  logic [mnc_pkg::GAddrW-1:0] grid_waddr,
  input  logic [32:0]          grid_wdata,
  input  logic                 kern_we,
  input  logic [mnc_pkg::KAddrW-1:0] kern_waddr,
  input  logic [16:0]          kern_wdata,
  input  logic [6:0]           tgt_col,
  input  logic [6:0]           tgt_row,
  input  logic [7:0]           cols_cfg,
  input  logic [7:0]           rows_cfg,
  input  logic [2:0]           rad_cfg,
  output logic [31:0]          res_value,
  output logic                 res_present,
  output logic [6:0]           res_col,
  output logic [6:0]           res_row
);
  import mnc_pkg::*;

  logic [32:0] grid_mem [GDepth];
  logic [16:0] kern_mem [KDepth];

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
    if (kern_we) kern_mem[kern_waddr] <= kern_wdata;
  end

  // window walk
  logic [3:0]  rad_r;
  logic [4:0]  side_r;
  logic [4:0]  wr_r, wc_r;          // 0..2R
  logic [KAddrW-1:0] kidx_r;
  logic [7:0]  col_r, row_r;        // target
  logic [7:0]  cols_r, rows_r;

  logic signed [9:0] pos_col, pos_row;
  logic in_grid;
  assign pos_col = $signed({2'b0, col_r}) + $signed({5'b0, wc_r}) - $signed({6'b0, rad_r});
  assign pos_row = $signed({2'b0, row_r}) + $signed({5'b0, wr_r}) - $signed({6'b0, rad_r});
  assign in_grid = !pos_col[9] && !pos_row[9] && (pos_col < $signed({2'b0, cols_r}))
                   && (pos_row < $signed({2'b0, rows_r}));
  assign stat.last_pos = (wr_r == side_r - 5'd1) && (wc_r == side_r - 5'd1);

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rad_r  <= {1'b0, rad_cfg};
      side_r <= {1'b0, rad_cfg, 1'b1};
      wr_r   <= '0;
      wc_r   <= '0;
      kidx_r <= '0;
      col_r  <= {1'b0, tgt_col};
      row_r  <= {1'b0, tgt_row};
      cols_r <= (cols_cfg > 8'(MaxCols)) ? 8'(MaxCols) : cols_cfg;
      rows_r <= (rows_cfg > 8'(MaxRows)) ? 8'(MaxRows) : rows_cfg;
    end else if (ctrl.step) begin
      kidx_r <= kidx_r + KAddrW'(1);
      if (wc_r == side_r - 5'd1) begin
        wc_r <= '0;
        wr_r <= wr_r + 5'd1;
      end else begin
        wc_r <= wc_r + 5'd1;
      end
    end
  end

  // stage 1: registered memory reads
  logic [32:0] gq_r;
  logic [16:0] kq_r;
  logic        v1_r, v2_r;
  always_ff @(posedge clk) begin
    gq_r <= grid_mem[{pos_row[RowW-1:0], pos_col[ColW-1:0]}];
    kq_r <= kern_mem[kidx_r];
  end

  // stage 2: product
  logic signed [49:0] prod_r;
  logic [16:0]        w2_r;
  always_ff @(posedge clk) begin
    prod_r <= $signed(gq_r[31:0]) * $signed({1'b0, kq_r});
    w2_r   <= kq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctrl.step && in_grid;
      v2_r <= v1_r && gq_r[32];
    end
  end
  assign stat.pipe_busy = v1_r || v2_r;

  // stage 3: accumulate
  logic signed [63:0] acc_r;
  logic [24:0]        wsum_r;
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc_r  <= '0;
      wsum_r <= '0;
    end else if (v2_r) begin
      acc_r  <= acc_r + 64'(prod_r);
      wsum_r <= wsum_r + 25'(w2_r);
    end
  end

  // restoring divider on magnitudes, one bit per cycle
  logic [63:0] quo_r;
  logic [25:0] rem_r;
  logic        neg_r;
  logic [25:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_r[24:0], quo_r[63]};
  assign rem_sub = rem_sh - {1'b0, wsum_r};

  always_ff @(posedge clk) begin
    if (ctrl.div_start) begin
      neg_r <= acc_r[63];
      quo_r <= acc_r[63] ? 64'(-acc_r) : acc_r;
      rem_r <= '0;
    end else if (ctrl.div_step) begin
      if (!rem_sub[25]) begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end

  // saturate; magnitude of 2^63 only possible as negative
  logic [31:0] sat_val;
  always_comb begin
    if (!neg_r) begin
      sat_val = (quo_r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_r[31:0];
    end else begin
      sat_val = (quo_r > 64'h8000_0000) ? 32'h8000_0000 : 32'(-quo_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      res_present <= (wsum_r != '0);
      res_value   <= (wsum_r != '0) ? sat_val : '0;
      res_col     <= col_r[6:0];
      res_row     <= row_r[6:0];
    end
  end

endmodule

// ===== rtl/mnc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mnc_ctrl
// Sequencer: window walk, pipeline drain, divide, result handoff.
// ----------------------------------------------------------------------------
module mnc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           smooth_go,
  output logic           busy,
  output mnc_pkg::ctrl_t ctrl,
  input  mnc_pkg::stat_t stat,
  output logic           out_valid,
  input  logic           out_ready
);
  import mnc_pkg::*;

  state_t state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE:  if (smooth_go) state_nxt = ST_WALK;
      ST_WALK:  if (stat.last_pos) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!stat.pipe_busy) begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(DivSteps)) state_nxt = ST_DONE;
      end
      ST_DONE:  if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // drain also issues div_start every cycle; the last one wins
  always_comb begin
    ctrl      = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        ctrl.start = smooth_go;
      end
      ST_WALK:  ctrl.step = 1'b1;
      ST_DRAIN: ctrl.div_start = 1'b1;
      ST_DIV: begin
        ctrl.div_step = (cnt_r < 7'(DivSteps));
        ctrl.finish   = (cnt_r == 7'(DivSteps));
      end
      ST_DONE:  out_valid = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |=> state_r == ST_DONE) else $error("finish not followed by done");
  a_no_step_div: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.step && ctrl.div_step)) else $error("walk and divide overlap");
  a_drain_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> !stat.pipe_busy) else $error("divide before drain");

endmodule

// ===== rtl/masked_normalized_convolution.sv =====
// ----------------------------------------------------------------------------
// masked_normalized_convolution
// Normalized convolution over a raster with absent cells.
// ----------------------------------------------------------------------------
// A smooth command walks all (2R+1)^2 window positions (R = radius setting),
// one window position per cycle, through a single grid read port and one
// multiplier, then runs a short pipeline drain, then a 64-step restoring
// divider producing one quotient bit per cycle. Only one smooth transaction
// is in progress at a time; the result stays in the output register until
// taken.
module masked_normalized_convolution (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [6:0]  in_cell_col,
  input  logic [6:0]  in_cell_row,
  input  logic signed [31:0] in_sample_value,
  input  logic        in_sample_present,
  input  logic [7:0]  in_kernel_index,
  input  logic [16:0] in_kernel_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_smoothed_value,
  output logic        out_smoothed_present,
  output logic [6:0]  out_result_col,
  output logic [6:0]  out_result_row,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import mnc_pkg::*;

  logic [7:0] cols_r, rows_r;
  logic [2:0] rad_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 8'd128;
      rows_r <= 8'd128;
      rad_r  <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS:   cols_r <= cfg_data;
        CFG_ROWS:   rows_r <= cfg_data;
        CFG_RADIUS: rad_r  <= cfg_data[2:0];
        default:    ;
      endcase
    end
  end

  logic busy, acc;
  ctrl_t ctrl;
  stat_t stat;
  logic [31:0] rv;

  assign in_ready = !busy;
  assign acc = in_valid && in_ready;

  logic kern_ok;
  assign kern_ok = (in_kernel_index < 8'(KDepth));

  mnc_ctrl u_ctrl (
    .clk, .rst_n,
    .smooth_go (acc && in_command == CMD_SMOOTH),
    .busy, .ctrl, .stat,
    .out_valid, .out_ready
  );

  mnc_datapath u_dp (
    .clk, .rst_n, .ctrl, .stat,
    .grid_we    (acc && in_command == CMD_LOAD_GRID),
    .grid_waddr ({in_cell_row[RowW-1:0], in_cell_col[ColW-1:0]}),
    .grid_wdata ({in_sample_present, in_sample_value}),
    .kern_we    (acc && in_command == CMD_LOAD_KERNEL && kern_ok),
    .kern_waddr (in_kernel_index[KAddrW-1:0]),
    .kern_wdata (in_kernel_weight),
    .tgt_col    (in_cell_col),
    .tgt_row    (in_cell_row),
    .cols_cfg   (cols_r),
    .rows_cfg   (rows_r),
    .rad_cfg    (rad_r),
    .res_value  (rv),
    .res_present(out_smoothed_present),
    .res_col    (out_result_col),
    .res_row    (out_result_row)
  );
  assign out_smoothed_value = $signed(rv);

  a_ready_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_smooth_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_command == CMD_SMOOTH) |=> busy) else $error("smooth not started");
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_smoothed_present) |-> out_smoothed_value == 0)
    else $error("absent result nonzero");

endmodule

// ===== tb/sv/mnc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mnc_checker
// Watches the input, result and register ports of the convolution block,
// keeps its own copy of both stores and the window settings, predicts each
// smoothed cell and compares results field by field in arrival order.
// ----------------------------------------------------------------------------
module mnc_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [6:0]         in_cell_col,
  input  logic [6:0]         in_cell_row,
  input  logic signed [31:0] in_sample_value,
  input  logic               in_sample_present,
  input  logic [7:0]         in_kernel_index,
  input  logic [16:0]        in_kernel_weight,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_smoothed_value,
  input  logic               out_smoothed_present,
  input  logic [6:0]         out_result_col,
  input  logic [6:0]         out_result_row,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 errors,
  output int                 pending
);
  import mnc_pkg::*;

  typedef struct {
    logic signed [31:0] value;
    logic               present;
    logic [6:0]         col;
    logic [6:0]         row;
  } cell_result_t;

  logic signed [31:0] grid_val [GDepth];
  bit                 grid_ok  [GDepth];
  bit [16:0]          weights  [KDepth];
  int unsigned        win_cols;
  int unsigned        win_rows;
  int unsigned        win_rad;
  cell_result_t       expected_cells [$];

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic cell_result_t smooth_cell(input int col, input int row);
    int cols;
    int rows;
    int rad;
    int side;
    int c;
    int r;
    int a;
    longint acc;
    longint wsum;
    longint w;
    longint q;
    cell_result_t res;
    cols = (win_cols > MaxCols) ? MaxCols : win_cols;
    rows = (win_rows > MaxRows) ? MaxRows : win_rows;
    rad  = (win_rad > MaxRadius) ? MaxRadius : win_rad;
    side = 2 * rad + 1;
    acc  = 0;
    wsum = 0;
    for (int dr = -rad; dr <= rad; dr++) begin
      for (int dc = -rad; dc <= rad; dc++) begin
        c = col + dc;
        r = row + dr;
        if (c < 0 || r < 0 || c >= cols || r >= rows) continue;
        a = r * MaxCols + c;
        if (!grid_ok[a]) continue;
        w = longint'(weights[(dr + rad) * side + (dc + rad)]);
        acc += longint'(grid_val[a]) * w;
        wsum += w;
      end
    end
    q = 0;
    res.present = 1'b0;
    if (wsum > 0) begin
      res.present = 1'b1;
      q = acc / wsum;
      if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
      if (q < -64'sh80000000) q = -64'sh80000000;
    end
    res.value = q[31:0];
    res.col   = col[6:0];
    res.row   = row[6:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      win_cols = MaxCols;
      win_rows = MaxRows;
      win_rad  = 1;
      errors   = 0;
      expected_cells.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_COLS:   win_cols = cfg_data;
          CFG_ROWS:   win_rows = cfg_data;
          CFG_RADIUS: win_rad  = cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (cmd_t'(in_command))
          CMD_LOAD_GRID: begin
            grid_val[in_cell_row * MaxCols + in_cell_col] = in_sample_value;
            grid_ok[in_cell_row * MaxCols + in_cell_col]  = in_sample_present;
          end
          CMD_LOAD_KERNEL: begin
            if (in_kernel_index < KDepth) weights[in_kernel_index] = in_kernel_weight;
          end
          CMD_SMOOTH: expected_cells.push_back(smooth_cell(in_cell_col, in_cell_row));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_cells.size() == 0) begin
          report($sformatf("unexpected result at (%0d,%0d)", out_result_col,
                           out_result_row));
        end else begin
          cell_result_t e;
          e = expected_cells.pop_front();
          if (out_smoothed_value !== e.value)
            report($sformatf("value %h, expected %h at (%0d,%0d)", out_smoothed_value,
                             e.value, e.col, e.row));
          if (out_smoothed_present !== e.present)
            report($sformatf("present %b, expected %b at (%0d,%0d)",
                             out_smoothed_present, e.present, e.col, e.row));
          if (out_result_col !== e.col)
            report($sformatf("col %0d, expected %0d", out_result_col, e.col));
          if (out_result_row !== e.row)
            report($sformatf("row %0d, expected %0d", out_result_row, e.row));
        end
      end
      pending <= expected_cells.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Fills the raster and kernel stores, then issues directed and random
// load/smooth traffic under several window settings and idle patterns,
// with one long result back-pressure stretch. The checker scores results.
// ----------------------------------------------------------------------------
module testbench;
  import mnc_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int DrainWait  = 310;
  localparam int HoldCycles = 3000;
  localparam int FillSide   = 12;
  localparam int PhaseItems = 80;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_command;
  logic [6:0]         in_cell_col;
  logic [6:0]         in_cell_row;
  logic signed [31:0] in_sample_value;
  logic               in_sample_present;
  logic [7:0]         in_kernel_index;
  logic [16:0]        in_kernel_weight;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_smoothed_value;
  logic               out_smoothed_present;
  logic [6:0]         out_result_col;
  logic [6:0]         out_result_row;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [7:0]         cfg_data;

  int errors;
  int pending;
  int idle_pct;
  int stall_pct;
  int hold_cnt;
  int cycles;
  logic hold_start;

  masked_normalized_convolution u_dut (.*);

  mnc_checker u_checker (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_start) begin
      hold_cnt  <= HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send(input cmd_t cmd, input int col, input int row,
                      input logic [31:0] val, input logic pres,
                      input int kidx, input int kw);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_cell_col       <= col[6:0];
    in_cell_row       <= row[6:0];
    in_sample_value   <= val;
    in_sample_present <= pres;
    in_kernel_index   <= kidx[7:0];
    in_kernel_weight  <= kw[16:0];
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[7:0];
    @(posedge clk);
  endtask

  task automatic set_window(input int cols, input int rows, input int rad);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_RADIUS, rad);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 65536;
      2:       return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  // windows never reach past the filled corner, grid size stays <= FillSide
  task automatic random_traffic(input int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 60)
        send(CMD_SMOOTH, $urandom_range(0, 15), $urandom_range(0, 15),
             $urandom, $urandom_range(0, 1), $urandom_range(0, 255), $urandom);
      else if (sel < 85)
        send(CMD_LOAD_GRID, $urandom_range(0, 15), $urandom_range(0, 15),
             pick_value(), ($urandom_range(0, 4) != 0), $urandom_range(0, 255),
             $urandom);
      else if (sel < 95)
        send(CMD_LOAD_KERNEL, $urandom_range(0, 127), $urandom_range(0, 127),
             $urandom, $urandom_range(0, 1), $urandom_range(0, 255), pick_weight());
      else
        send(CMD_NONE, $urandom_range(0, 127), $urandom_range(0, 127),
             $urandom, $urandom_range(0, 1), $urandom_range(0, 255), $urandom);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_command        = CMD_NONE;
    in_cell_col       = '0;
    in_cell_row       = '0;
    in_sample_value   = '0;
    in_sample_present = 1'b0;
    in_kernel_index   = '0;
    in_kernel_weight  = '0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_COLS;
    cfg_data          = '0;
    hold_start        = 1'b0;
    idle_pct          = 0;
    stall_pct         = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // grid corner and whole kernel defined before any window read
    for (int r = 0; r < FillSide; r++)
      for (int c = 0; c < FillSide; c++)
        send(CMD_LOAD_GRID, c, r, pick_value(), ($urandom_range(0, 4) != 0), 0, 0);
    for (int k = 0; k < KDepth; k++)
      send(CMD_LOAD_KERNEL, 0, 0, 0, 1'b0, k, pick_weight());

    // directed
    set_window(FillSide, FillSide, 1);
    send(CMD_SMOOTH, 0, 0, 0, 1'b0, 0, 0);
    send(CMD_SMOOTH, FillSide - 1, FillSide - 1, 0, 1'b0, 0, 0);
    send(CMD_LOAD_GRID, 5, 5, 32'h7FFF_FFFF, 1'b1, 0, 0);
    send(CMD_LOAD_GRID, 6, 5, 32'h8000_0000, 1'b1, 0, 0);
    send(CMD_LOAD_GRID, 5, 6, 32'h1234_5678, 1'b0, 0, 0);
    send(CMD_LOAD_KERNEL, 0, 0, 0, 1'b0, 0, 0);
    send(CMD_LOAD_KERNEL, 0, 0, 0, 1'b0, 4, 65536);
    send(CMD_LOAD_KERNEL, 0, 0, 0, 1'b0, 8, 131071);
    send(CMD_LOAD_KERNEL, 0, 0, 0, 1'b0, 225, 7);   // beyond store: ignored
    send(CMD_LOAD_KERNEL, 0, 0, 0, 1'b0, 255, 9);
    send(CMD_NONE, 5, 5, 32'hFFFF_FFFF, 1'b1, 255, 131071);
    send(CMD_SMOOTH, 5, 5, 0, 1'b0, 0, 0);
    send(CMD_SMOOTH, 6, 6, 0, 1'b0, 0, 0);
    send(CMD_SMOOTH, 64, 64, 0, 1'b0, 0, 0);        // target outside grid
    set_window(0, 128, 1);                          // empty grid: absent
    send(CMD_SMOOTH, 3, 3, 0, 1'b0, 0, 0);
    set_window(200, 255, 7);                        // saturating sizes
    send(CMD_SMOOTH, 0, 0, 0, 1'b0, 0, 0);
    send(CMD_SMOOTH, 2, 3, 0, 1'b0, 0, 0);
    set_window(1, 1, 0);
    send(CMD_SMOOTH, 0, 0, 0, 1'b0, 0, 0);
    send(CMD_SMOOTH, 9, 9, 0, 1'b0, 0, 0);          // target outside grid

    // random phases
    set_window(FillSide, FillSide, 7);
    idle_pct = 0;  stall_pct = 0;
    random_traffic(PhaseItems);
    set_window(1, FillSide, 0);
    idle_pct = 47; stall_pct = 0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    random_traffic(PhaseItems);
    set_window(FillSide, 3, 3);
    idle_pct = 0;  stall_pct = 47;
    random_traffic(PhaseItems);
    set_window(FillSide, FillSide, $urandom_range(0, 7));
    idle_pct = 13; stall_pct = 13;
    random_traffic(PhaseItems);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
